// ===== src/dasd_pkg.sv =====
// ----------------------------------------------------------------------------
// dasd_pkg
// shared types, constants and calendar helpers for the date shifter
// ----------------------------------------------------------------------------
package dasd_pkg;

    // day offset width
    localparam int OFFSET_BITS = 16;
    // signed working day count: holds day + offset and day - offset
    localparam int D_W = OFFSET_BITS + 2;

    localparam logic [13:0] YEAR_MIN  = 14'd1601;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] CYCLE_LEN = 14'd400;   // gregorian cycle in years

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUB = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // restoring mod 7 reduction: subtract 7 << k for k = MOD_TOP downto 0
    localparam logic [3:0] MOD_TOP = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YRED,
        S_CHECK,
        S_WALK,
        S_WLOAD,
        S_WRED,
        S_WSUM,
        S_MOD7,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic red_step;
        logic check;
        logic walk;
        logic wred_load;
        logic wsum;
        logic mod_step;
    } t_dp_cmd;

    typedef struct packed {
        logic red_done;
        logic valid;
        logic over_max;
        logic walk_done;
        logic mod_last;
    } t_dp_status;

    // leap test from year mod 400
    function automatic logic is_leap(input logic [8:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 with march-based month numbering
    function automatic logic [4:0] month_shift(input logic [3:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/date_add_subtract_days.sv =====
// ----------------------------------------------------------------------------
// date_add_subtract_days
// gregorian date plus or minus an unsigned day count, with weekday
// ----------------------------------------------------------------------------
// one request at a time: a request is taken when start is high and busy is
// low, and its result appears for exactly one cycle with o_done high; the
// receiver cannot stall it, so capture the result ports on that cycle.
// steps of a request, in order: capture, year mod 400 reduction, check,
// the month walker (one month per cycle), a reload and second pass of the
// same reducer on yy for the weekday, the weekday sum, mod 7 (one bit per
// cycle) and the result strobe.
// the month walker makes up most of the time for long offsets; an invalid
// start date skips the walk and the weekday, and a start year above the
// range skips only the walk.
// result fields stay valid after the strobe until the next request is taken.
// ----------------------------------------------------------------------------
module date_add_subtract_days (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [4:0]                          i_day,
    input  logic [3:0]                          i_month,
    input  logic [13:0]                         i_year,
    input  logic [dasd_pkg::OFFSET_BITS-1:0]    i_offset_days,
    output logic                                o_done,
    output logic [4:0]                          o_result_day,
    output logic [3:0]                          o_result_month,
    output logic [13:0]                         o_result_year,
    output logic [2:0]                          o_weekday,
    output logic                                o_input_valid,
    output logic                                o_out_of_range
);

    // commands from the sequencer, status back from the datapath
    dasd_pkg::t_dp_cmd    w_cmd;
    dasd_pkg::t_dp_status w_status;

    // sequencer: reduce, check, walk months, weekday, strobe
    dasd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // datapath: request copy, month walker, shared mod 400 reducer, mod 7 unit
    dasd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_command      (i_command),
        .i_day          (i_day),
        .i_month        (i_month),
        .i_year         (i_year),
        .i_offset_days  (i_offset_days),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_weekday      (o_weekday),
        .o_input_valid  (o_input_valid),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== src/dasd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dasd_ctrl
// sequencer for the date shifter: issues datapath commands per phase
// ----------------------------------------------------------------------------
module dasd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  dasd_pkg::t_dp_status  i_status,
    output dasd_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    dasd_pkg::t_state r_state;
    dasd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dasd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            dasd_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = dasd_pkg::S_YRED;
                end
            end
            dasd_pkg::S_YRED: begin
                if (i_status.red_done) begin
                    n_state = dasd_pkg::S_CHECK;
                end else begin
                    o_cmd.red_step = 1'b1;
                end
            end
            dasd_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                if (!i_status.valid) begin
                    n_state = dasd_pkg::S_DONE;
                end else if (i_status.over_max) begin
                    n_state = dasd_pkg::S_WLOAD;
                end else begin
                    n_state = dasd_pkg::S_WALK;
                end
            end
            dasd_pkg::S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = dasd_pkg::S_WLOAD;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            dasd_pkg::S_WLOAD: begin
                o_cmd.wred_load = 1'b1;
                n_state         = dasd_pkg::S_WRED;
            end
            dasd_pkg::S_WRED: begin
                if (i_status.red_done) begin
                    n_state = dasd_pkg::S_WSUM;
                end else begin
                    o_cmd.red_step = 1'b1;
                end
            end
            dasd_pkg::S_WSUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = dasd_pkg::S_MOD7;
            end
            dasd_pkg::S_MOD7: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = dasd_pkg::S_DONE;
                end
            end
            dasd_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = dasd_pkg::S_IDLE;
            end
            default: begin
                n_state = dasd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/dasd_datapath.sv =====
// ----------------------------------------------------------------------------
// dasd_datapath
// month walker, year mod 400 reducer and weekday reduction
// ----------------------------------------------------------------------------
module dasd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dasd_pkg::t_dp_cmd                   i_cmd,
    output dasd_pkg::t_dp_status                o_status,
    input  logic                                i_command,
    input  logic [4:0]                          i_day,
    input  logic [3:0]                          i_month,
    input  logic [13:0]                         i_year,
    input  logic [dasd_pkg::OFFSET_BITS-1:0]    i_offset_days,
    output logic [4:0]                          o_result_day,
    output logic [3:0]                          o_result_month,
    output logic [13:0]                         o_result_year,
    output logic [2:0]                          o_weekday,
    output logic                                o_input_valid,
    output logic                                o_out_of_range
);

    // request copy
    logic                                r_cmd;
    logic [4:0]                          r_day0;
    logic [3:0]                          r_month0;
    logic [13:0]                         r_year0;
    logic [dasd_pkg::OFFSET_BITS-1:0]    r_off;

    // walking date
    logic signed [dasd_pkg::D_W-1:0]     r_d;
    logic [3:0]                          r_m;
    logic [13:0]                         r_y;
    logic [8:0]                          r_r400;

    // shared reducer: value mod 400 and quotient
    logic [13:0]                         r_red;
    logic [5:0]                          r_q;

    // weekday sum and mod 7 step
    logic [14:0]                         r_s;
    logic [3:0]                          r_k;

    logic                                r_valid;
    logic                                r_oor;

    // walk helpers
    logic                                w_leap_cur;
    logic [4:0]                          w_mlen_cur;
    logic [3:0]                          w_m_prev;
    logic [8:0]                          w_r_prev;
    logic [4:0]                          w_mlen_prev;
    logic signed [dasd_pkg::D_W-1:0]     w_mlen_cur_s;
    logic signed [dasd_pkg::D_W-1:0]     w_mlen_prev_s;
    logic                                w_more;
    logic                                w_wrap_up;
    logic                                w_wrap_dn;

    // check helpers
    logic                                w_valid;
    logic                                w_over;
    logic signed [dasd_pkg::D_W-1:0]     w_day_s;
    logic signed [dasd_pkg::D_W-1:0]     w_off_s;

    // weekday helpers
    logic [13:0]                         w_yy;
    logic [1:0]                          w_cent;
    logic [14:0]                         w_sum;
    logic [14:0]                         w_sub;

    always_comb begin
        w_leap_cur    = dasd_pkg::is_leap(r_r400);
        w_mlen_cur    = dasd_pkg::month_len(r_m, w_leap_cur);
        w_m_prev      = (r_m == dasd_pkg::MONTH_JAN) ? dasd_pkg::MONTH_DEC : r_m - 4'd1;
        if (r_m == dasd_pkg::MONTH_JAN) begin
            w_r_prev = (r_r400 == 9'd0) ? 9'd399 : r_r400 - 9'd1;
        end else begin
            w_r_prev = r_r400;
        end
        w_mlen_prev   = dasd_pkg::month_len(w_m_prev, dasd_pkg::is_leap(w_r_prev));
        w_mlen_cur_s  = signed'(dasd_pkg::D_W'(w_mlen_cur));
        w_mlen_prev_s = signed'(dasd_pkg::D_W'(w_mlen_prev));
        w_more        = (r_cmd == dasd_pkg::CMD_SUB) ? (r_d < signed'(dasd_pkg::D_W'(1)))
                                                     : (r_d > w_mlen_cur_s);
        w_wrap_up     = (r_m == dasd_pkg::MONTH_DEC);
        w_wrap_dn     = (r_m == dasd_pkg::MONTH_JAN);

        w_valid = (r_year0 >= dasd_pkg::YEAR_MIN) && (r_month0 >= 4'd1) &&
                  (r_month0 <= dasd_pkg::MONTH_DEC) && (r_day0 >= 5'd1) &&
                  (r_day0 <= dasd_pkg::month_len(r_month0, dasd_pkg::is_leap(r_red[8:0])));
        w_over  = r_year0 > dasd_pkg::YEAR_MAX;
        w_day_s = signed'(dasd_pkg::D_W'(r_day0));
        w_off_s = signed'(dasd_pkg::D_W'(r_off));

        // january and february count in the previous year
        w_yy = r_y - ((r_m <= dasd_pkg::MONTH_FEB) ? 14'd1 : 14'd0);

        // r_red < 400 here: whole centuries in the remainder
        if (r_red >= 14'd300) begin
            w_cent = 2'd3;
        end else if (r_red >= 14'd200) begin
            w_cent = 2'd2;
        end else if (r_red >= 14'd100) begin
            w_cent = 2'd1;
        end else begin
            w_cent = 2'd0;
        end
        // d + yy + yy/4 - yy/100 + yy/400 + month term, with yy = 400q + r
        w_sum = 15'(r_d[4:0]) + 15'(r_y) - ((r_m <= dasd_pkg::MONTH_FEB) ? 15'd1 : 15'd0)
              + 15'(r_q) * 15'd97 + 15'(r_red[13:2]) - 15'(w_cent)
              + 15'(dasd_pkg::month_shift(r_m));

        w_sub = 15'd7 << r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_oor   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmd    <= i_command;
                r_day0   <= i_day;
                r_month0 <= i_month;
                r_year0  <= i_year;
                r_off    <= i_offset_days;
                r_m      <= i_month;
                r_y      <= i_year;
                r_red    <= i_year;
                r_q      <= 6'd0;
            end
            if (i_cmd.red_step && (r_red >= dasd_pkg::CYCLE_LEN)) begin
                r_red <= r_red - dasd_pkg::CYCLE_LEN;
                r_q   <= r_q + 6'd1;
            end
            if (i_cmd.check) begin
                r_valid <= w_valid;
                r_oor   <= w_valid && w_over;
                r_r400  <= r_red[8:0];
                if (w_valid && !w_over) begin
                    r_d <= (r_cmd == dasd_pkg::CMD_SUB) ? w_day_s - w_off_s : w_day_s + w_off_s;
                end else begin
                    r_d <= w_day_s;
                end
            end
            if (i_cmd.walk) begin
                if (r_cmd == dasd_pkg::CMD_SUB) begin
                    if (w_wrap_dn && (r_y == dasd_pkg::YEAR_MIN)) begin
                        // leaving the range: echo the request date
                        r_oor <= 1'b1;
                        r_d   <= w_day_s;
                        r_m   <= r_month0;
                        r_y   <= r_year0;
                    end else begin
                        r_d    <= r_d + w_mlen_prev_s;
                        r_m    <= w_m_prev;
                        r_r400 <= w_r_prev;
                        if (w_wrap_dn) begin
                            r_y <= r_y - 14'd1;
                        end
                    end
                end else begin
                    if (w_wrap_up && (r_y == dasd_pkg::YEAR_MAX)) begin
                        r_oor <= 1'b1;
                        r_d   <= w_day_s;
                        r_m   <= r_month0;
                        r_y   <= r_year0;
                    end else begin
                        r_d <= r_d - w_mlen_cur_s;
                        if (w_wrap_up) begin
                            r_m    <= dasd_pkg::MONTH_JAN;
                            r_y    <= r_y + 14'd1;
                            r_r400 <= (r_r400 == 9'd399) ? 9'd0 : r_r400 + 9'd1;
                        end else begin
                            r_m <= r_m + 4'd1;
                        end
                    end
                end
            end
            if (i_cmd.wred_load) begin
                r_red <= w_yy;
                r_q   <= 6'd0;
            end
            if (i_cmd.wsum) begin
                r_s <= w_sum;
                r_k <= dasd_pkg::MOD_TOP;
            end
            if (i_cmd.mod_step) begin
                if (r_s >= w_sub) begin
                    r_s <= r_s - w_sub;
                end
                r_k <= r_k - 4'd1;
            end
        end
    end

    assign o_status.red_done  = r_red < dasd_pkg::CYCLE_LEN;
    assign o_status.valid     = w_valid;
    assign o_status.over_max  = w_over;
    assign o_status.walk_done = r_oor || !w_more;
    assign o_status.mod_last  = (r_k == 4'd0);

    assign o_result_day   = r_d[4:0];
    assign o_result_month = r_m;
    assign o_result_year  = r_y;
    assign o_weekday      = r_valid ? r_s[2:0] : 3'd0;
    assign o_input_valid  = r_valid;
    assign o_out_of_range = r_oor;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the date shifter: a short table of directed
// requests, then randomized requests in bursts, every result compared field
// by field against a hand-written value or a calendar predictor in the bench
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD     = 5;
    // directed table holds 25 rows, so this lands near 270 requests in all
    localparam int RANDOM_REQUESTS = 245;
    // longest request: the full month walk plus reducer, check and weekday
    localparam int DRAIN_CYCLES    = 2400;

    // one request as the block sees it
    typedef struct packed {
        logic                             cmd;
        logic [4:0]                       day;
        logic [3:0]                       month;
        logic [13:0]                      year;
        logic [dasd_pkg::OFFSET_BITS-1:0] offset;
    } t_date_req;

    // one result as the block returns it
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic        valid;
        logic        oor;
    } t_date_res;

    // directed table row: typed rows carry the result, others use the predictor
    typedef struct packed {
        t_date_req req;
        logic      typed;
        t_date_res res;
    } t_table_row;

    logic                             i_clk          = 1'b0;
    logic                             i_rst_n        = 1'b0;
    logic                             start          = 1'b0;
    logic                             i_command      = dasd_pkg::CMD_ADD;
    logic [4:0]                       i_day          = '0;
    logic [3:0]                       i_month        = '0;
    logic [13:0]                      i_year         = '0;
    logic [dasd_pkg::OFFSET_BITS-1:0] i_offset_days  = '0;
    logic                             busy;
    logic                             o_done;
    logic [4:0]                       o_result_day;
    logic [3:0]                       o_result_month;
    logic [13:0]                      o_result_year;
    logic [2:0]                       o_weekday;
    logic                             o_input_valid;
    logic                             o_out_of_range;

    t_date_res  pending_dates[$];   // expected results, oldest first
    t_table_row directed_rows[$];
    int         mismatch_count = 0;

    date_add_subtract_days dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_day          (i_day),
        .i_month        (i_month),
        .i_year         (i_year),
        .i_offset_days  (i_offset_days),
        .o_done         (o_done),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_weekday      (o_weekday),
        .o_input_valid  (o_input_valid),
        .o_out_of_range (o_out_of_range)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------------

    // divisible by 4, except centuries not divisible by 400
    function automatic bit gregorian_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = gregorian_leap(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // zeller-style sum with march as month one, 0 = sunday
    function automatic int day_of_week(input int d, input int m, input int y);
        int a;
        int yy;
        int mm;
        int s;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        s  = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
        return s % 7;
    endfunction

    // walk the date month by month; on leaving the year range echo the start
    function automatic t_date_res shift_date(input t_date_req r);
        int        d;
        int        m;
        int        y;
        int        off;
        bit        ok;
        bit        oor;
        t_date_res res;
        d   = int'(r.day);
        m   = int'(r.month);
        y   = int'(r.year);
        off = int'(r.offset);
        oor = 1'b0;
        ok  = (y >= int'(dasd_pkg::YEAR_MIN)) && (m >= 1) && (m <= 12) &&
              (d >= 1) && (d <= days_in_month(m, y));
        res.weekday = '0;
        if (ok) begin
            if (y > int'(dasd_pkg::YEAR_MAX)) begin
                oor = 1'b1;
            end else if (r.cmd == dasd_pkg::CMD_ADD) begin
                d = d + off;
                while (d > days_in_month(m, y)) begin
                    d = d - days_in_month(m, y);
                    m = m + 1;
                    if (m > 12) begin
                        m = 1;
                        y = y + 1;
                        if (y > int'(dasd_pkg::YEAR_MAX)) begin
                            oor = 1'b1;
                            break;
                        end
                    end
                end
            end else begin
                // step back a month first, then add that month's length
                d = d - off;
                while (d < 1) begin
                    m = m - 1;
                    if (m < 1) begin
                        m = 12;
                        y = y - 1;
                        if (y < int'(dasd_pkg::YEAR_MIN)) begin
                            oor = 1'b1;
                            break;
                        end
                    end
                    d = d + days_in_month(m, y);
                end
            end
            if (oor) begin
                d = int'(r.day);
                m = int'(r.month);
                y = int'(r.year);
            end
            res.weekday = 3'(day_of_week(d, m, y));
        end
        res.day   = 5'(d);
        res.month = 4'(m);
        res.year  = 14'(y);
        res.valid = ok;
        res.oor   = oor;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // directed table building
    // ------------------------------------------------------------------------

    // row checked against the predictor
    task automatic add_row(input logic cmd, input int d, input int m, input int y,
                           input int off);
        t_table_row row;
        row.req   = '{cmd, 5'(d), 4'(m), 14'(y), dasd_pkg::OFFSET_BITS'(off)};
        row.typed = 1'b0;
        row.res   = '0;
        directed_rows.push_back(row);
    endtask

    // row whose result is written out by hand
    task automatic add_typed(input logic cmd, input int d, input int m, input int y,
                             input int off, input int rd, input int rm, input int ry,
                             input int wd, input bit v, input bit o);
        t_table_row row;
        row.req   = '{cmd, 5'(d), 4'(m), 14'(y), dasd_pkg::OFFSET_BITS'(off)};
        row.typed = 1'b1;
        row.res   = '{5'(rd), 4'(rm), 14'(ry), 3'(wd), v, o};
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // request driver and checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    endtask

    // called at a falling edge; holds the request until it is taken and
    // returns at the following falling edge with start still high
    task automatic send_date(input t_date_req r, input bit typed, input t_date_res want);
        i_command     <= r.cmd;
        i_day         <= r.day;
        i_month       <= r.month;
        i_year        <= r.year;
        i_offset_days <= r.offset;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // taken at this edge
        if (typed)
            pending_dates.push_back(want);
        else
            pending_dates.push_back(shift_date(r));
        @(negedge i_clk);
    endtask

    // start low for the given gap; a gap of zero keeps start high
    task automatic idle_gap(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // start low until every outstanding request has returned
    task automatic drain_requests();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_dates.size() != 0) @(negedge i_clk);
    endtask

    // random gap length: often none, mostly short, now and then long
    function automatic int random_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return 0;
        else if (sel < 90)
            return $urandom_range(12, 1);
        else
            return $urandom_range(300, 13);
    endfunction

    // results are sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        t_date_res want;
        if (i_rst_n && o_done) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result with no request, day", int'(o_result_day), 0);
            end else begin
                want = pending_dates.pop_front();
                if (o_result_day !== want.day)
                    report_mismatch("result_day", int'(o_result_day), int'(want.day));
                if (o_result_month !== want.month)
                    report_mismatch("result_month", int'(o_result_month), int'(want.month));
                if (o_result_year !== want.year)
                    report_mismatch("result_year", int'(o_result_year), int'(want.year));
                if (o_weekday !== want.weekday)
                    report_mismatch("weekday", int'(o_weekday), int'(want.weekday));
                if (o_input_valid !== want.valid)
                    report_mismatch("input_valid", int'(o_input_valid), int'(want.valid));
                if (o_out_of_range !== want.oor)
                    report_mismatch("out_of_range", int'(o_out_of_range), int'(want.oor));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_date_req  r;
        t_table_row row;
        int         burst_left;
        int         kind;
        int         sel;
        int         yr;
        int         mo;

        // invalid start dates: fields echoed, weekday 0, both flags low
        add_typed(dasd_pkg::CMD_ADD, 0, 1, 2000, 5, 0, 1, 2000, 0, 0, 0);
        add_typed(dasd_pkg::CMD_SUB, 31, 4, 2000, 10, 31, 4, 2000, 0, 0, 0);
        add_typed(dasd_pkg::CMD_ADD, 15, 0, 2000, 100, 15, 0, 2000, 0, 0, 0);
        add_typed(dasd_pkg::CMD_SUB, 1, 13, 2000, 1, 1, 13, 2000, 0, 0, 0);
        add_typed(dasd_pkg::CMD_ADD, 29, 2, 1900, 1, 29, 2, 1900, 0, 0, 0);
        add_typed(dasd_pkg::CMD_ADD, 10, 6, 1600, 0, 10, 6, 1600, 0, 0, 0);
        add_typed(dasd_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_typed(dasd_pkg::CMD_SUB, 31, 15, 16383, 65535, 31, 15, 16383, 0, 0, 0);
        // leaving the year range: start echoed with its own weekday
        add_typed(dasd_pkg::CMD_SUB, 1, 1, 1601, 1, 1, 1, 1601, 1, 1, 1);
        add_typed(dasd_pkg::CMD_ADD, 31, 12, 9999, 1, 31, 12, 9999, 5, 1, 1);
        // zero offset on a known saturday
        add_typed(dasd_pkg::CMD_ADD, 1, 1, 2000, 0, 1, 1, 2000, 6, 1, 0);
        // leap days and the start year above the top of the range
        add_row(dasd_pkg::CMD_ADD, 29, 2, 2000, 0);
        add_row(dasd_pkg::CMD_SUB, 29, 2, 2004, 366);
        add_row(dasd_pkg::CMD_ADD, 31, 12, 16383, 0);
        // largest offset from both ends of the range
        add_row(dasd_pkg::CMD_ADD, 1, 1, 1601, 65535);
        add_row(dasd_pkg::CMD_SUB, 31, 12, 9999, 65535);
        // month and year boundaries, with the previous month's length on subtract
        add_row(dasd_pkg::CMD_ADD, 28, 2, 2000, 1);
        add_row(dasd_pkg::CMD_ADD, 28, 2, 1900, 1);
        add_row(dasd_pkg::CMD_SUB, 1, 3, 2000, 1);
        add_row(dasd_pkg::CMD_SUB, 1, 3, 2100, 1);
        add_row(dasd_pkg::CMD_SUB, 1, 1, 2001, 1);
        // just inside and just outside the range at both ends
        add_row(dasd_pkg::CMD_ADD, 1, 1, 9999, 364);
        add_row(dasd_pkg::CMD_ADD, 1, 1, 9999, 365);
        add_row(dasd_pkg::CMD_SUB, 31, 12, 1601, 364);
        add_row(dasd_pkg::CMD_SUB, 31, 12, 1601, 365);

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part, with gaps between some requests
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_date(row.req, row.typed, row.res);
            idle_gap(random_gap());
        end

        // hold off until the table has fully returned
        drain_requests();

        // random part: bursts of back-to-back requests with gaps in between
        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2)
                drain_requests();

            kind = $urandom_range(99);
            if (kind < 15) begin
                // noise over the full field widths
                r.cmd    = 1'($urandom);
                r.day    = 5'($urandom);
                r.month  = 4'($urandom);
                r.year   = 14'($urandom);
                r.offset = dasd_pkg::OFFSET_BITS'($urandom);
            end else begin
                // well-formed date, year picked to reach the range edges often
                if (kind < 27)
                    yr = $urandom_range(1610, 1601);
                else if (kind < 39)
                    yr = $urandom_range(9999, 9990);
                else if (kind < 44)
                    yr = $urandom_range(16383, 10000);
                else
                    yr = $urandom_range(9999, 1601);
                mo       = $urandom_range(12, 1);
                r.cmd    = 1'($urandom);
                r.year   = 14'(yr);
                r.month  = 4'(mo);
                r.day    = 5'($urandom_range(days_in_month(mo, yr), 1));
                // mostly short walks, a few across the full offset
                sel = $urandom_range(99);
                if (sel < 70)
                    r.offset = dasd_pkg::OFFSET_BITS'($urandom_range(400));
                else if (sel < 90)
                    r.offset = dasd_pkg::OFFSET_BITS'($urandom_range(8000));
                else
                    r.offset = dasd_pkg::OFFSET_BITS'($urandom_range(65535));
            end

            send_date(r, 1'b0, '0);

            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 1);
                idle_gap(random_gap());
            end else begin
                burst_left--;
            end
        end

        // wait out everything in flight, then a full request's worth
        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("PASS date_add_subtract_days");
        else
            $display("FAIL date_add_subtract_days");
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("FAIL date_add_subtract_days");
        $finish;
    end

endmodule

// ===== date_add_subtract_days.f =====
src/dasd_pkg.sv
src/dasd_ctrl.sv
src/dasd_datapath.sv
src/date_add_subtract_days.sv
sim/tb_top.sv
